@@ rtl/core/size_sorted_free_list_best_fit_assert.svh @@
// Assertion macros for the free list RTL.
`ifndef SIZE_SORTED_FREE_LIST_BEST_FIT_ASSERT_SVH
`define SIZE_SORTED_FREE_LIST_BEST_FIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SSFL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSFL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ssfl_pkg.sv @@
// Types, constants and codes for the size-sorted free list.
`timescale 1ns / 1ps

package ssfl_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int ADDR_W      = 32;
	localparam int SIZE_W      = 31;
	localparam int MIN_W       = 16;
	localparam int STATUS_W    = 3;

	localparam logic [MIN_W-1:0] MIN_SIZE_RESET = 16'd16;

	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_GET = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MISS    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SMALL   = 3'd4;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
	} entry_t;

	// Broadcast to every cell each cycle.
	typedef struct packed {
		logic   ins;
		logic   del;
		entry_t word;
	} cell_ctl_t;

endpackage

@@ rtl/core/size_sorted_free_list_best_fit.sv @@
// Top level of the best-fit free list: cell row, fill count and result register.
`timescale 1ns / 1ps

// Best-fit free block list, kept sorted by size in a row of MAX_ENTRIES cells.
// Pulse start with func/block_address/block_size; busy is always low, so a
// word may be started every cycle. Each word yields exactly one result word,
// shown on status/granted_address/granted_size with done high for one cycle,
// the cycle right after start. There is no back-pressure: the receiver must
// take the result in that cycle. Every cell compares its own size against the
// request. On an insert the cells at or past the point load from their left
// neighbor (the first of them from the request word), on a removal from the
// right, all in the same clock. min_block_size is written with cfg_we/cfg_wdata
// only while no word is in flight: the user must ensure it, the block does not.

module size_sorted_free_list_best_fit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ssfl_pkg::MIN_W-1:0]     cfg_wdata,
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [ssfl_pkg::ADDR_W-1:0]    block_address,
	input  logic [ssfl_pkg::SIZE_W-1:0]    block_size,
	output logic                           done,
	output logic [ssfl_pkg::STATUS_W-1:0]  status,
	output logic [ssfl_pkg::ADDR_W-1:0]    granted_address,
	output logic [ssfl_pkg::SIZE_W-1:0]    granted_size
);
	import ssfl_pkg::*;

	`include "size_sorted_free_list_best_fit_assert.svh"

	logic [MIN_W-1:0]       min_size_q;
	logic [CNT_W-1:0]       entry_count_q;
	logic                   done_q;
	logic [STATUS_W-1:0]    status_q;
	logic [ADDR_W-1:0]      g_addr_q;
	logic [SIZE_W-1:0]      g_size_q;

	logic                   accept;
	logic                   is_add;
	logic                   too_small;
	logic                   full;
	logic                   hit;
	cell_ctl_t              ctl;
	logic [MAX_ENTRIES-1:0] valid;
	logic [MAX_ENTRIES-1:0] ge;
	logic [MAX_ENTRIES-1:0] at;
	entry_t                 cell_entry [MAX_ENTRIES];
	entry_t                 grant;

	// One word per cycle, never stalls.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_add = (func == FUNC_ADD);

	assign too_small = block_size < {{(SIZE_W-MIN_W){1'b0}}, min_size_q};
	assign full      = (entry_count_q == CNT_W'(MAX_ENTRIES));
	assign hit       = |ge;

	assign ctl.ins       = accept && is_add && !too_small && !full;
	assign ctl.del       = accept && !is_add && hit;
	assign ctl.word.addr = block_address;
	assign ctl.word.size = block_size;

	// Cell row
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		assign valid[i] = CNT_W'(i) < entry_count_q;

		if (i == 0) begin : g_head
			ssfl_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.valid       (valid[i]),
				.at_left     (1'b0),
				.left_entry  (ctl.word),
				.right_entry (cell_entry[(i+1) % MAX_ENTRIES]),
				.ge          (ge[i]),
				.at          (at[i]),
				.entry       (cell_entry[i])
			);
		end else if (i == MAX_ENTRIES - 1) begin : g_tail
			// Tail takes its own value on removal; it falls out of the count.
			ssfl_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.valid       (valid[i]),
				.at_left     (at[i-1]),
				.left_entry  (cell_entry[i-1]),
				.right_entry (cell_entry[i]),
				.ge          (ge[i]),
				.at          (at[i]),
				.entry       (cell_entry[i])
			);
		end else begin : g_mid
			ssfl_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.valid       (valid[i]),
				.at_left     (at[i-1]),
				.left_entry  (cell_entry[i-1]),
				.right_entry (cell_entry[i+1]),
				.ge          (ge[i]),
				.at          (at[i]),
				.entry       (cell_entry[i])
			);
		end
	end

	// Grant select: first cell with ge set (one-hot edge of the thermometer).
	always_comb begin
		grant = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (ge[i] && (i == 0 || !ge[(i+MAX_ENTRIES-1) % MAX_ENTRIES])) begin
				grant = grant | cell_entry[i];
			end
		end
	end

	// Config register, fill count and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_size_q    <= MIN_SIZE_RESET;
			entry_count_q <= '0;
			done_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_size_q <= cfg_wdata;
			end
			if (ctl.ins) begin
				entry_count_q <= entry_count_q + CNT_W'(1);
			end else if (ctl.del) begin
				entry_count_q <= entry_count_q - CNT_W'(1);
			end
			done_q <= accept;
		end
	end

	// Result register, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_add) begin
				g_addr_q <= '0;
				g_size_q <= '0;
				if (too_small) begin
					status_q <= ST_SMALL;
				end else if (full) begin
					status_q <= ST_FULL;
				end else begin
					status_q <= ST_ADDED;
				end
			end else if (hit) begin
				status_q <= ST_GRANTED;
				g_addr_q <= grant.addr;
				g_size_q <= grant.size;
			end else begin
				status_q <= ST_MISS;
				g_addr_q <= '0;
				g_size_q <= '0;
			end
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign granted_address = g_addr_q;
	assign granted_size    = g_size_q;

	`SSFL_ASSERT_NEXT(a_result_follows, accept, done_q, "accepted word gave no result")
	`SSFL_ASSERT_NOW(a_idle_zero, done_q && status_q != ST_GRANTED, g_addr_q == '0 && g_size_q == '0, "non-grant result carries data")
	`SSFL_ASSERT_NEXT(a_grant_shrinks, ctl.del, entry_count_q == $past(entry_count_q) - CNT_W'(1) && status_q == ST_GRANTED, "grant did not remove an entry")
	`SSFL_ASSERT_NEXT(a_add_grows, ctl.ins, entry_count_q == $past(entry_count_q) + CNT_W'(1) && status_q == ST_ADDED, "add did not place an entry")
	`SSFL_ASSERT_NOW(a_count_bound, 1'b1, entry_count_q <= CNT_W'(MAX_ENTRIES), "fill count past table size")

endmodule

@@ rtl/core/ssfl_cell.sv @@
// One slot of the sorted free list: holds an entry, shifts left or right.
`timescale 1ns / 1ps

module ssfl_cell (
	input  logic              clk,
	input  ssfl_pkg::cell_ctl_t ctl,
	input  logic              valid,
	input  logic              at_left,
	input  ssfl_pkg::entry_t  left_entry,
	input  ssfl_pkg::entry_t  right_entry,
	output logic              ge,
	output logic              at,
	output ssfl_pkg::entry_t  entry
);
	import ssfl_pkg::*;

	entry_t entry_q;

	// Sizes ascend along the row, so ge is a thermometer over valid cells.
	assign ge    = valid && (entry_q.size >= ctl.word.size);
	// At or past the insert/remove point.
	assign at    = ge || !valid;
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && at) begin
			entry_q <= at_left ? left_entry : ctl.word;
		end else if (ctl.del && at) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ sim/size_sorted_free_list_best_fit_tb.sv @@
// Self-checking testbench for the size-sorted best-fit free list.
`timescale 1ns / 1ps

// Request words and register writes are queued up front by one initial block.
// A falling-edge driver presents them and a rising-edge monitor checks every
// result word. At each accepted request word, a private copy of the sorted
// free table works out the one result word it must produce. The run passes
// through four minimum-size settings: reset value, 1, 65535 and 0, plus a
// random one. The sender idles 17% of cycles first, then 48%, then never.

module size_sorted_free_list_best_fit_tb;

	import ssfl_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int RESET_CYC   = 10;
	// No accept, result or register write for this long means the block hung.
	// The longest correct quiet stretch is a run of sender idle cycles at 48%,
	// plus the settling wait before a register write.
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYC  = 2;  // result comes in the cycle after start

	typedef enum logic [1:0] {
		TOK_WORD,   // request word for the block
		TOK_CFG,    // write of min_block_size, only once the block is idle
		TOK_PAUSE,  // hold off until every outstanding result has come
		TOK_IDLE    // change the sender idle percentage
	} tok_kind_e;

	typedef struct packed {
		tok_kind_e          kind;
		logic               func;
		logic [ADDR_W-1:0]  addr;
		logic [SIZE_W-1:0]  size;
		logic [31:0]        value;
	} req_tok_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   addr;
		logic [SIZE_W-1:0]   size;
	} outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [MIN_W-1:0]      cfg_wdata = '0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  func = FUNC_ADD;
	logic [ADDR_W-1:0]     block_address = '0;
	logic [SIZE_W-1:0]     block_size = '0;
	logic                  done;
	logic [STATUS_W-1:0]   status;
	logic [ADDR_W-1:0]     granted_address;
	logic [SIZE_W-1:0]     granted_size;

	// Stimulus and expectations
	req_tok_t  request_q [$];
	outcome_t  outcome_q [$];

	// Predictor's own copy of the free table, sorted by size, newest first
	// among equal sizes.
	logic [ADDR_W-1:0]  fl_addr [MAX_ENTRIES];
	logic [SIZE_W-1:0]  fl_size [MAX_ENTRIES];
	int                 fl_count = 0;
	logic [MIN_W-1:0]   min_size_cur = MIN_SIZE_RESET;

	int unsigned gen_min = MIN_SIZE_RESET;  // min size as seen by the generator
	int          idle_pct = 0;
	int          settle = 0;
	logic        taken = 1'b0;
	int          stall_cnt = 0;
	int          err_cnt = 0;
	int          words_in = 0;
	int          cfg_writes = 0;
	int          tally [5] = '{default: 0};

	size_sorted_free_list_best_fit DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.block_address   (block_address),
		.block_size      (block_size),
		.done            (done),
		.status          (status),
		.granted_address (granted_address),
		.granted_size    (granted_size)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Applies one accepted request word to the table copy and returns the
	// result word the block owes for it.
	function automatic outcome_t apply_to_free_list(logic f, logic [ADDR_W-1:0] a,
			logic [SIZE_W-1:0] s);
		outcome_t o;
		int pos;
		int i;
		o.status = ST_ADDED;
		o.addr = '0;
		o.size = '0;
		// first entry at least as large as the request (fl_count if none)
		pos = fl_count;
		for (i = fl_count - 1; i >= 0; i--) begin
			if (fl_size[i] >= s)
				pos = i;
		end
		if (f == FUNC_ADD) begin
			// size check wins over the full check
			if (s < min_size_cur)
				o.status = ST_SMALL;
			else if (fl_count >= MAX_ENTRIES)
				o.status = ST_FULL;
			else begin
				for (i = fl_count; i > pos; i--) begin
					fl_addr[i] = fl_addr[i - 1];
					fl_size[i] = fl_size[i - 1];
				end
				fl_addr[pos] = a;
				fl_size[pos] = s;
				fl_count++;
			end
		end else if (pos >= fl_count) begin
			o.status = ST_MISS;
		end else begin
			o.status = ST_GRANTED;
			o.addr = fl_addr[pos];
			o.size = fl_size[pos];
			for (i = pos; i < fl_count - 1; i++) begin
				fl_addr[i] = fl_addr[i + 1];
				fl_size[i] = fl_size[i + 1];
			end
			fl_count--;
		end
		return o;
	endfunction

	task automatic push_word(logic f, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s);
		req_tok_t t;
		t.kind = TOK_WORD;
		t.func = f;
		t.addr = a;
		t.size = s;
		t.value = '0;
		request_q.push_back(t);
	endtask

	task automatic push_ctl(tok_kind_e k, int unsigned v);
		req_tok_t t;
		t.kind = k;
		t.func = FUNC_ADD;
		t.addr = '0;
		t.size = '0;
		t.value = v;
		request_q.push_back(t);
		if (k == TOK_CFG)
			gen_min = v;
	endtask

	// Sizes cluster just above the minimum so that equal sizes, near misses
	// and best-fit choices between close sizes come up often; the rest covers
	// the whole 31-bit range, undersized adds and the tiny end.
	function automatic logic [SIZE_W-1:0] rand_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return (gen_min == 0) ? '0 : SIZE_W'($urandom_range(gen_min - 1));
		else if (r < 60)
			return SIZE_W'(gen_min + $urandom_range(40));
		else if (r < 75)
			return SIZE_W'(gen_min + $urandom_range(4000));
		else if (r < 92)
			return SIZE_W'($urandom);
		else if (r < 96)
			return {SIZE_W{1'b1}};
		return SIZE_W'($urandom_range(3));
	endfunction

	// Random traffic in bursts: each burst leans toward adds or gets, so the
	// table fills up to full and drains down to misses again and again.
	task automatic push_random_words(int n);
		int left;
		int burst;
		int add_pct;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(40, 8);
			case ($urandom_range(3))
				0: add_pct = 25;
				1: add_pct = 50;
				2: add_pct = 75;
				default: add_pct = 90;
			endcase
			while (burst > 0 && left > 0) begin
				push_word(($urandom_range(99) < add_pct) ? FUNC_ADD : FUNC_GET,
					$urandom, rand_size());
				if ($urandom_range(59) == 0)
					push_ctl(TOK_PAUSE, 0);
				burst--;
				left--;
			end
		end
	endtask

	// Driver: presents queued tokens at the falling edge. A word stays up
	// until the block takes it; a write or pause waits for an idle block.
	always @(negedge clk) begin : drive_words
		req_tok_t         tok;
		logic             n_start;
		logic             n_we;
		logic             n_func;
		logic [ADDR_W-1:0] n_addr;
		logic [SIZE_W-1:0] n_size;
		logic [MIN_W-1:0]  n_wdata;
		n_start = 1'b0;
		n_we = 1'b0;
		n_func = func;
		n_addr = block_address;
		n_size = block_size;
		n_wdata = cfg_wdata;
		if (outcome_q.size() == 0 && !start)
			settle++;
		else
			settle = 0;
		if (arst_n) begin
			if (start && !taken) begin
				n_start = 1'b1;  // not taken yet, hold the word
			end else if (request_q.size() != 0) begin
				tok = request_q[0];
				case (tok.kind)
					TOK_WORD: begin
						if ($urandom_range(99) >= idle_pct) begin
							n_start = 1'b1;
							n_func = tok.func;
							n_addr = tok.addr;
							n_size = tok.size;
						end
					end
					TOK_CFG: begin
						if (settle >= SETTLE_CYC) begin
							n_we = 1'b1;
							n_wdata = tok.value[MIN_W-1:0];
							min_size_cur = tok.value[MIN_W-1:0];
							cfg_writes++;
							void'(request_q.pop_front());
						end
					end
					TOK_PAUSE: begin
						if (settle >= SETTLE_CYC)
							void'(request_q.pop_front());
					end
					default: begin
						idle_pct = tok.value;
						void'(request_q.pop_front());
					end
				endcase
			end
		end
		start <= n_start;
		cfg_we <= n_we;
		func <= n_func;
		block_address <= n_addr;
		block_size <= n_size;
		cfg_wdata <= n_wdata;
	end

	// Accept side: the word on the ports at this edge is the queue head.
	always @(posedge clk) begin : accept_words
		if (arst_n) begin
			taken <= start && !busy;
			if (start && !busy) begin
				outcome_q.push_back(apply_to_free_list(func, block_address, block_size));
				void'(request_q.pop_front());
				words_in++;
			end
		end
	end

	// Monitor: every done cycle carries one result word, checked against the
	// oldest expectation field by field.
	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && done) begin
			if (status <= ST_SMALL)
				tally[status]++;
			if (outcome_q.size() == 0) begin
				$display("%0t: result word with nothing outstanding, expected none, got status %0d",
					$time, status);
				err_cnt++;
			end else begin
				want = outcome_q.pop_front();
				if (status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, want.status, status);
					err_cnt++;
				end
				if (granted_address !== want.addr) begin
					$display("%0t: granted_address mismatch, expected %h, got %h",
						$time, want.addr, granted_address);
					err_cnt++;
				end
				if (granted_size !== want.size) begin
					$display("%0t: granted_size mismatch, expected %h, got %h",
						$time, want.size, granted_size);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog: any handshake resets the count.
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((start && !busy) || done || cfg_we)
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, outcome_q.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int i;
		// --- phase 1: sender idles 17% of the time, reset minimum of 16
		push_ctl(TOK_IDLE, 17);
		push_word(FUNC_GET, 32'h5A5A_5A5A, 31'd1);           // get on empty table
		push_word(FUNC_ADD, 32'h0000_0000, 31'd16);          // exactly the minimum
		push_word(FUNC_ADD, 32'h0000_1234, 31'd15);          // one below minimum
		push_word(FUNC_ADD, 32'hFFFF_FFFF, {SIZE_W{1'b1}});  // largest block
		push_word(FUNC_ADD, 32'h0000_A000, 31'd40);
		push_word(FUNC_ADD, 32'h0000_B000, 31'd40);          // same size, goes first
		push_word(FUNC_ADD, 32'h0000_C000, 31'd20);
		push_word(FUNC_GET, 32'hFFFF_FFFF, 31'd0);           // size zero: smallest
		push_word(FUNC_GET, 32'h0000_0000, 31'd40);          // newest of the 40s
		push_word(FUNC_GET, 32'h1234_5678, {SIZE_W{1'b1}});
		push_word(FUNC_GET, 32'h1234_5678, {SIZE_W{1'b1}});  // miss now
		for (i = 0; i < MAX_ENTRIES - 2; i++)
			push_word(FUNC_ADD, $urandom, SIZE_W'(16 + $urandom_range(63)));
		push_word(FUNC_ADD, 32'hDEAD_0000, 31'd100);         // table full
		push_word(FUNC_ADD, 32'hDEAD_0001, 31'd3);           // too small beats full
		push_ctl(TOK_PAUSE, 0);
		push_random_words(360);
		push_ctl(TOK_CFG, 1);
		push_random_words(140);
		// --- phase 2: sender idles 48% of the time
		push_ctl(TOK_IDLE, 48);
		push_ctl(TOK_CFG, 16'hFFFF);
		push_random_words(110);
		// empty the table so the zero-size adds below get in
		for (i = 0; i <= MAX_ENTRIES; i++)
			push_word(FUNC_GET, $urandom, 31'd0);
		push_ctl(TOK_CFG, 0);
		push_word(FUNC_ADD, 32'h0BAD_F00D, 31'd0);           // zero minimum lets size 0 in
		push_word(FUNC_ADD, 32'h0BAD_F00E, 31'd0);
		push_word(FUNC_GET, 32'h0000_0000, 31'd0);
		push_random_words(150);
		// --- phase 3: no idling
		push_ctl(TOK_IDLE, 0);
		push_ctl(TOK_CFG, $urandom_range(16'hFFFF, 1));
		push_random_words(200);
		push_ctl(TOK_CFG, MIN_SIZE_RESET);
		push_random_words(140);

		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (request_q.size() == 0 && outcome_q.size() == 0 && !start);
		repeat (SETTLE_CYC + 3) @(posedge clk);
		$display("Covered %0d request words across %0d min-size writes (0, 1, 65535 included):",
			words_in, cfg_writes);
		$display("  %0d added, %0d granted, %0d misses, %0d full-table, %0d undersized",
			tally[ST_ADDED], tally[ST_GRANTED], tally[ST_MISS], tally[ST_FULL],
			tally[ST_SMALL]);
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ size_sorted_free_list_best_fit.f @@
+incdir+rtl/core
rtl/core/ssfl_pkg.sv
rtl/core/ssfl_cell.sv
rtl/core/size_sorted_free_list_best_fit.sv
sim/size_sorted_free_list_best_fit_tb.sv
